>>> rtl/lbm_pkg.sv
`default_nettype none

package lbm_pkg;

   // field widths fixed by the stream format
   localparam int LABEL_FIELD_W = 16;
   localparam int SIZE_W        = 11;
   localparam int THR_W         = 4;
   localparam int COLOR_W       = 24;
   localparam int POS_W         = 10;
   localparam int CFG_INDEX_W   = 2;
   localparam int CFG_DATA_W    = 24;
   localparam int RSP_DATA_W    = 48;
   localparam int COUNT_W       = 4;

   localparam logic [SIZE_W-1:0]  WIDTH_RESET     = 11'd640;
   localparam logic [SIZE_W-1:0]  HEIGHT_RESET    = 11'd480;
   localparam logic [THR_W-1:0]   THRESHOLD_RESET = 4'd1;
   localparam logic [COLOR_W-1:0] COLOR_RESET     = 24'd0;

   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_FLUSH = 1'b1;

   typedef enum logic [CFG_INDEX_W-1:0] {
      CFG_IMAGE_WIDTH,
      CFG_IMAGE_HEIGHT,
      CFG_NEIGHBOR_THRESHOLD,
      CFG_PAINT_COLOR
   } cfg_index_type;

   // neighbors: window column (0 = left), window row (0 = above), tap in the
   // 3x3 window with index column*3 + row
   localparam logic [1:0] NB_COL [8] = '{2'd0, 2'd0, 2'd1, 2'd2, 2'd2, 2'd2, 2'd1, 2'd0};
   localparam logic [1:0] NB_ROW [8] = '{2'd1, 2'd0, 2'd0, 2'd0, 2'd1, 2'd2, 2'd2, 2'd2};
   localparam logic [3:0] NB_TAP [8] = '{4'd1, 4'd0, 4'd3, 4'd6, 4'd7, 4'd8, 4'd5, 4'd2};
   localparam logic [3:0] CENTER_TAP = 4'd4;

   typedef struct packed {
      logic               frame_last;
      logic [COLOR_W-1:0] edge_color;
      logic [POS_W-1:0]   pixel_y;
      logic [POS_W-1:0]   pixel_x;
      logic               is_edge;
   } rsp_type;

endpackage

`default_nettype wire

>>> rtl/lbm_ram.sv
`default_nettype none

module lbm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read returns the old contents when both ports hit one address
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/label_boundary_marker.sv
`default_nettype none

// channel  dir  handshake             payload
// req      in   req_tvalid/tready     tdata: label; tuser: operation
// rsp      out  rsp_tvalid/tready     tdata: is_edge, pixel_x, pixel_y, edge_color;
//                                     tlast: frame_last
// csr      in   csr_write_enable      csr_index, csr_wdata
//
// one word per cycle while req_tready is high; a word goes through the window compare in one pass
// into the result register, so the result it completes (if any) shows the cycle after it is taken
// the line stores have registered reads, addressed one word ahead of the column
// reset clears positions, window, bypass flag and result valid and loads the configuration defaults;
// line stores start unknown and are only read after being written within the frame
// req_tready drops only while a result sits unconsumed and rsp_tready is low

module label_boundary_marker #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024,
   parameter int LABEL_BITS = 16
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   input  wire logic [lbm_pkg::LABEL_FIELD_W-1:0]    req_tdata,   // label
   input  wire logic                                 req_tuser,   // operation
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // is_edge, pixel_x, pixel_y, edge_color, zero fill
   output logic [lbm_pkg::RSP_DATA_W-1:0]            rsp_tdata,
   output logic                                      rsp_tlast,
   input  wire logic                                 csr_write_enable,
   input  wire logic [lbm_pkg::CFG_INDEX_W-1:0]      csr_index,
   input  wire logic [lbm_pkg::CFG_DATA_W-1:0]       csr_wdata
);

   localparam int COL_B = $clog2(MAX_WIDTH);
   localparam int COL_W = COL_B + 1;
   localparam int ROW_W = $clog2(MAX_HEIGHT) + 1;
   localparam int ORW_B = ROW_W - 1;

   // configuration
   logic [lbm_pkg::SIZE_W-1:0]  cfg_width_ff;
   logic [lbm_pkg::SIZE_W-1:0]  cfg_height_ff;
   logic [lbm_pkg::THR_W-1:0]   cfg_thr_ff;
   logic [lbm_pkg::COLOR_W-1:0] cfg_color_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_width_ff  <= lbm_pkg::WIDTH_RESET;
         cfg_height_ff <= lbm_pkg::HEIGHT_RESET;
         cfg_thr_ff    <= lbm_pkg::THRESHOLD_RESET;
         cfg_color_ff  <= lbm_pkg::COLOR_RESET;
      end else if (csr_write_enable) begin
         unique case (lbm_pkg::cfg_index_type'(csr_index))
            lbm_pkg::CFG_IMAGE_WIDTH:        cfg_width_ff  <= csr_wdata[lbm_pkg::SIZE_W-1:0];
            lbm_pkg::CFG_IMAGE_HEIGHT:       cfg_height_ff <= csr_wdata[lbm_pkg::SIZE_W-1:0];
            lbm_pkg::CFG_NEIGHBOR_THRESHOLD: cfg_thr_ff    <= csr_wdata[lbm_pkg::THR_W-1:0];
            lbm_pkg::CFG_PAINT_COLOR:        cfg_color_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // sizes clamped to 1..max
   logic [COL_W-1:0] width_eff;
   logic [ROW_W-1:0] height_eff;

   always_comb begin
      if (cfg_width_ff == '0) begin
         width_eff = COL_W'(1);
      end else if (32'(cfg_width_ff) > MAX_WIDTH) begin
         width_eff = COL_W'(MAX_WIDTH);
      end else begin
         width_eff = COL_W'(cfg_width_ff);
      end
      if (cfg_height_ff == '0) begin
         height_eff = ROW_W'(1);
      end else if (32'(cfg_height_ff) > MAX_HEIGHT) begin
         height_eff = ROW_W'(MAX_HEIGHT);
      end else begin
         height_eff = ROW_W'(cfg_height_ff);
      end
   end

   // positions
   logic [COL_B-1:0] in_col_ff, in_col_in, col_next;
   logic [ROW_W-1:0] in_row_ff, in_row_in, row_next;
   logic [COL_B-1:0] out_col_ff, out_col_in;
   logic [ORW_B-1:0] out_row_ff, out_row_in;

   // window: model columns 1 and 2 (index col*3+row minus 3)
   logic [LABEL_BITS-1:0] win_ff [6];
   logic [LABEL_BITS-1:0] win_next [9];

   // line stores and read bypass
   logic [LABEL_BITS-1:0] older_q, newer_q, older_rd, newer_rd;
   logic [LABEL_BITS-1:0] older_byp_ff, newer_byp_ff;
   logic                  byp_ff, byp_in;

   logic                  accept, flushing, step, ready, last;
   logic [LABEL_BITS-1:0] lab;

   // result register
   logic             rsp_valid_ff, rsp_valid_in;
   lbm_pkg::rsp_type rsp_ff, rsp_in;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign flushing   = in_row_ff >= height_eff;
   assign step       = accept && (flushing || req_tuser != lbm_pkg::OP_FLUSH);
   assign ready      = (in_row_ff >= ROW_W'(2)) ||
                       (in_row_ff == ROW_W'(1) && in_col_ff != '0);
   assign lab        = flushing ? '0 : LABEL_BITS'(32'(req_tdata));

   assign older_rd = byp_ff ? older_byp_ff : older_q;
   assign newer_rd = byp_ff ? newer_byp_ff : newer_q;

   // boundary test on the shifted window
   logic [LABEL_BITS-1:0]        center;
   logic [2:0]                   x_ok, y_ok;
   logic [COL_W-1:0]             oc_ext;
   logic [ROW_W-1:0]             or_ext;
   logic [lbm_pkg::COUNT_W-1:0]  diff_count;
   logic                         is_edge;

   always_comb begin
      for (int k = 0; k < 6; k++) begin
         win_next[k] = win_ff[k];
      end
      win_next[6] = older_rd;
      win_next[7] = newer_rd;
      win_next[8] = lab;
      center = win_next[lbm_pkg::CENTER_TAP];

      oc_ext = COL_W'(out_col_ff);
      or_ext = ROW_W'(out_row_ff);
      x_ok[0] = (oc_ext != '0) && (oc_ext - COL_W'(1) < width_eff);
      x_ok[1] = oc_ext < width_eff;
      x_ok[2] = oc_ext + COL_W'(1) < width_eff;
      y_ok[0] = (or_ext != '0) && (or_ext - ROW_W'(1) < height_eff);
      y_ok[1] = or_ext < height_eff;
      y_ok[2] = or_ext + ROW_W'(1) < height_eff;

      diff_count = '0;
      for (int k = 0; k < 8; k++) begin
         if (x_ok[lbm_pkg::NB_COL[k]] && y_ok[lbm_pkg::NB_ROW[k]] &&
             win_next[lbm_pkg::NB_TAP[k]] != center) begin
            diff_count = diff_count + lbm_pkg::COUNT_W'(1);
         end
      end
      is_edge = diff_count > cfg_thr_ff;
      last    = ready && (or_ext + ROW_W'(1) >= height_eff) &&
                (oc_ext + COL_W'(1) >= width_eff);
   end

   // position updates
   always_comb begin
      if (last) begin
         col_next = '0;
         row_next = '0;
      end else if (COL_W'(in_col_ff) + COL_W'(1) >= width_eff) begin
         col_next = '0;
         row_next = (in_row_ff != '1) ? in_row_ff + ROW_W'(1) : in_row_ff;
      end else begin
         col_next = in_col_ff + COL_B'(1);
         row_next = in_row_ff;
      end
      in_col_in = step ? col_next : in_col_ff;
      in_row_in = step ? row_next : in_row_ff;
      byp_in    = step && (col_next == in_col_ff);

      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      if (step && ready) begin
         if (last) begin
            out_col_in = '0;
            out_row_in = '0;
         end else if (oc_ext + COL_W'(1) >= width_eff) begin
            out_col_in = '0;
            out_row_in = out_row_ff + ORW_B'(1);
         end else begin
            out_col_in = out_col_ff + COL_B'(1);
         end
      end
   end

   always_comb begin
      rsp_in.is_edge    = is_edge;
      rsp_in.pixel_x    = lbm_pkg::POS_W'(32'(out_col_ff));
      rsp_in.pixel_y    = lbm_pkg::POS_W'(32'(out_row_ff));
      rsp_in.edge_color = is_edge ? cfg_color_ff : '0;
      rsp_in.frame_last = last;

      if (step && ready) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff    <= '0;
         in_row_ff    <= '0;
         out_col_ff   <= '0;
         out_row_ff   <= '0;
         byp_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < 6; k++) begin
            win_ff[k] <= '0;
         end
      end else begin
         in_col_ff    <= in_col_in;
         in_row_ff    <= in_row_in;
         out_col_ff   <= out_col_in;
         out_row_ff   <= out_row_in;
         byp_ff       <= byp_in;
         rsp_valid_ff <= rsp_valid_in;
         if (step) begin
            for (int k = 0; k < 6; k++) begin
               win_ff[k] <= win_next[k + 3];
            end
         end
      end
   end

   // the word just written is forwarded when the next read hits the same column
   always_ff @(posedge clock) begin
      older_byp_ff <= newer_rd;
      newer_byp_ff <= lab;
      if (step && ready) begin
         rsp_ff <= rsp_in;
      end
   end

   lbm_ram #(
      .WIDTH (LABEL_BITS),
      .DEPTH (MAX_WIDTH)
   ) u_older_ram (
      .clock   (clock),
      .wr_en   (step),
      .wr_addr (in_col_ff),
      .wr_data (newer_rd),
      .rd_addr (in_col_in),
      .rd_data (older_q)
   );

   lbm_ram #(
      .WIDTH (LABEL_BITS),
      .DEPTH (MAX_WIDTH)
   ) u_newer_ram (
      .clock   (clock),
      .wr_en   (step),
      .wr_addr (in_col_ff),
      .wr_data (lab),
      .rd_addr (in_col_in),
      .rd_data (newer_q)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_ff.edge_color, rsp_ff.pixel_y, rsp_ff.pixel_x,
                        rsp_ff.is_edge};
   assign rsp_tlast  = rsp_ff.frame_last;

endmodule

`default_nettype wire
